>>> rtl/voxel_face_culling_mesher_macros.svh
// assertion macros for the voxel face culling mesher checker
// no dependencies; included by the checker file only
`ifndef VOXEL_FACE_CULLING_MESHER_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_MACROS_SVH

// property checked only while out of reset
`define VFCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vfcm assertion failed");

// property checked on every edge, reset included
`define VFCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vfcm assertion failed");

`endif

>>> rtl/vfcm_pkg.sv
// shared types, codes and helper functions of the voxel face culling mesher
// no dependencies; imported by every module of the block except vfcm_ram
package vfcm_pkg;

    localparam int DEF_SIZE_X        = 16;
    localparam int DEF_SIZE_Y        = 16;
    localparam int DEF_SIZE_Z        = 16;
    localparam int DEF_MAX_MATERIALS = 8;

    localparam int CODE_W  = 4;
    localparam int COORD_W = 4;
    localparam int CNT_W   = 17;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // request function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_MESH  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // face directions, in test order
    localparam logic [2:0] DIR_PX = 3'd0;
    localparam logic [2:0] DIR_PY = 3'd1;
    localparam logic [2:0] DIR_NX = 3'd2;
    localparam logic [2:0] DIR_NY = 3'd3;
    localparam logic [2:0] DIR_PZ = 3'd4;
    localparam logic [2:0] DIR_NZ = 3'd5;

    // register indexes
    localparam logic [1:0] REG_AIR    = 2'd0;
    localparam logic [1:0] REG_WATER  = 2'd1;
    localparam logic [1:0] REG_TRUNK  = 2'd2;
    localparam logic [1:0] REG_MATCNT = 2'd3;

    localparam logic [CODE_W-1:0] AIR_RST    = 4'd0;
    localparam logic [CODE_W-1:0] WATER_RST  = 4'd7;
    localparam logic [CODE_W-1:0] TRUNK_RST  = 4'd6;
    localparam logic [CODE_W-1:0] MATCNT_RST = 4'd8;

    localparam logic [4:0]       MAT_BIAS     = 5'd2;
    localparam logic [CNT_W-1:0] VTX_PER_FACE = 17'd4;

    typedef struct packed {
        logic [CODE_W-1:0] air;
        logic [CODE_W-1:0] water;
        logic [CODE_W-1:0] trunk;
        logic [CODE_W-1:0] mat_count;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [2:0]         dir;
        logic [2:0]         mat;
        logic [CNT_W-1:0]   base;
        logic               last;
    } t_face;

    // neighbor position, one extra bit for the step past the top
    typedef struct packed {
        logic [COORD_W:0] x;
        logic [COORD_W:0] y;
        logic [COORD_W:0] z;
        logic             under;
    } t_nbr;

    function automatic t_nbr nbr_pos(input logic [2:0] dir, input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [COORD_W-1:0] z);
        t_nbr n;
        n.x     = {1'b0, x};
        n.y     = {1'b0, y};
        n.z     = {1'b0, z};
        n.under = 1'b0;
        unique case (dir)
            DIR_PX: n.x = {1'b0, x} + 5'd1;
            DIR_PY: n.y = {1'b0, y} + 5'd1;
            DIR_NX: begin
                n.x     = {1'b0, x} - 5'd1;
                n.under = (x == '0);
            end
            DIR_NY: begin
                n.y     = {1'b0, y} - 5'd1;
                n.under = (y == '0);
            end
            DIR_PZ: n.z = {1'b0, z} + 5'd1;
            DIR_NZ: begin
                n.z     = {1'b0, z} - 5'd1;
                n.under = (z == '0);
            end
            default: n.under = 1'b1;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/vfcm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module vfcm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/vfcm_cfg.sv
// apb register file holding the block codes and the material count
// depends on vfcm_pkg
module vfcm_cfg
    import vfcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg        r_cfg;
    logic        wr;
    logic [1:0]  idx;
    logic [CODE_W-1:0] rd_val;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.air       <= AIR_RST;
            r_cfg.water     <= WATER_RST;
            r_cfg.trunk     <= TRUNK_RST;
            r_cfg.mat_count <= MATCNT_RST;
        end else if (wr) begin
            unique case (idx)
                REG_AIR:    r_cfg.air       <= pwdata[CODE_W-1:0];
                REG_WATER:  r_cfg.water     <= pwdata[CODE_W-1:0];
                REG_TRUNK:  r_cfg.trunk     <= pwdata[CODE_W-1:0];
                REG_MATCNT: r_cfg.mat_count <= pwdata[CODE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_AIR:    rd_val = r_cfg.air;
            REG_WATER:  rd_val = r_cfg.water;
            REG_TRUNK:  rd_val = r_cfg.trunk;
            REG_MATCNT: rd_val = r_cfg.mat_count;
            default:    rd_val = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-CODE_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

>>> rtl/vfcm_ctrl.sv
// sequencer: walks one request through the voxel ram a neighbor per cycle while the face output
// is not stalled, keeps the vertex counters and the face output register; depends on vfcm_pkg
module vfcm_ctrl
    import vfcm_pkg::*;
#(
    parameter int SIZE_X        = DEF_SIZE_X,
    parameter int SIZE_Y        = DEF_SIZE_Y,
    parameter int SIZE_Z        = DEF_SIZE_Z,
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS,
    parameter int AW            = $clog2(SIZE_X) + $clog2(SIZE_Y) + $clog2(SIZE_Z)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [COORD_W-1:0] i_pos_z,
    input  logic [CODE_W-1:0]  i_block_code,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [CODE_W-1:0]  o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [CODE_W-1:0]  i_ram_rdata,
    output logic               o_valid,
    input  logic               i_stall,
    output t_face              o_face
);

    localparam int CXW = $clog2(SIZE_X);
    localparam int CYW = $clog2(SIZE_Y);
    localparam int CZW = $clog2(SIZE_Z);
    localparam int MW  = (MAX_MATERIALS > 1) ? $clog2(MAX_MATERIALS) : 1;

    localparam logic [8:0] SX9 = 9'(SIZE_X);
    localparam logic [8:0] SY9 = 9'(SIZE_Y);
    localparam logic [8:0] SZ9 = 9'(SIZE_Z);
    localparam logic [4:0] MAXM5 = 5'(MAX_MATERIALS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_CENTER = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_dir, n_dir;
    logic               r_pend_valid, n_pend_valid;
    logic [2:0]         r_pend_dir, n_pend_dir;
    logic [MW-1:0]      r_mat, n_mat;
    logic               r_force, n_force;
    logic [1:0]         r_func;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [CODE_W-1:0]  r_code;

    logic [CNT_W-1:0]   r_cnt [MAX_MATERIALS];
    logic               r_out_valid;
    t_face              r_face;

    logic       accept;
    logic       out_free;
    logic       in_chunk;
    logic       push, push_last;
    logic       clear;
    logic       rd_center;
    logic       emit, blocked, nbr_open, nbr_out;
    logic [2:0] sel_dir;
    t_nbr       nb_test, nb_sel;
    logic [4:0] eff, mat_raw, mat_cl;
    logic       force_face;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign in_chunk = (9'(r_x) < SX9) && (9'(r_y) < SY9) && (9'(r_z) < SZ9);

    // neighbor under test and neighbor whose code is fetched this cycle
    assign nb_test = nbr_pos(r_dir, r_x, r_y, r_z);
    assign nb_sel  = nbr_pos(sel_dir, r_x, r_y, r_z);
    assign nbr_out = nb_test.under || (9'(nb_test.x) >= SX9) || (9'(nb_test.y) >= SY9)
                     || (9'(nb_test.z) >= SZ9);
    assign nbr_open = nbr_out || (i_ram_rdata == i_cfg.air) || (i_ram_rdata == i_cfg.water);

    // material of the center voxel, clamped to the effective count
    always_comb begin
        if (i_cfg.mat_count == '0) begin
            eff = 5'd1;
        end else if ({1'b0, i_cfg.mat_count} > MAXM5) begin
            eff = MAXM5;
        end else begin
            eff = {1'b0, i_cfg.mat_count};
        end
        mat_raw    = (i_ram_rdata < CODE_W'(MAT_BIAS)) ? 5'd0 : ({1'b0, i_ram_rdata} - MAT_BIAS);
        mat_cl     = (mat_raw > eff - 5'd1) ? (eff - 5'd1) : mat_raw;
        force_face = (i_cfg.trunk >= CODE_W'(MAT_BIAS))
                     && (mat_cl == ({1'b0, i_cfg.trunk} - MAT_BIAS));
    end

    always_comb begin
        n_state      = r_state;
        n_dir        = r_dir;
        n_pend_valid = r_pend_valid;
        n_pend_dir   = r_pend_dir;
        n_mat        = r_mat;
        n_force      = r_force;
        push         = 1'b0;
        push_last    = 1'b0;
        clear        = 1'b0;
        o_ram_we     = 1'b0;
        rd_center    = 1'b0;
        sel_dir      = r_dir;
        emit         = r_force || nbr_open;
        blocked      = emit && r_pend_valid && !out_free;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                if (r_func == FUNC_CLEAR) begin
                    clear = 1'b1;
                end else if (in_chunk && r_func == FUNC_WRITE) begin
                    o_ram_we = 1'b1;
                end else if (in_chunk && r_func == FUNC_MESH) begin
                    rd_center = 1'b1;
                    n_state   = S_CENTER;
                end
            end
            S_CENTER: begin
                if (i_ram_rdata == i_cfg.air) begin
                    n_state = S_IDLE;
                end else begin
                    n_mat        = MW'(mat_cl);
                    n_force      = force_face;
                    n_dir        = DIR_PX;
                    sel_dir      = DIR_PX;
                    n_pend_valid = 1'b0;
                    n_state      = S_TEST;
                end
            end
            S_TEST: begin
                // a face waits in the pending slot until the next one shows
                // whether it was the last
                if (!blocked) begin
                    if (emit) begin
                        push         = r_pend_valid;
                        n_pend_valid = 1'b1;
                        n_pend_dir   = r_dir;
                    end
                    if (r_dir == DIR_NZ) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_dir   = r_dir + 3'd1;
                        sel_dir = r_dir + 3'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ram_waddr = {CZW'(r_z), CYW'(r_y), CXW'(r_x)};
    assign o_ram_wdata = r_code;
    assign o_ram_raddr = rd_center ? {CZW'(r_z), CYW'(r_y), CXW'(r_x)}
                                   : {CZW'(nb_sel.z), CYW'(nb_sel.y), CXW'(nb_sel.x)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dir        <= DIR_PX;
            r_pend_valid <= 1'b0;
            r_pend_dir   <= DIR_PX;
            r_mat        <= '0;
            r_force      <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_MATERIALS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_dir        <= n_dir;
            r_pend_valid <= n_pend_valid;
            r_pend_dir   <= n_pend_dir;
            r_mat        <= n_mat;
            r_force      <= n_force;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (clear) begin
                for (int i = 0; i < MAX_MATERIALS; i++) begin
                    r_cnt[i] <= '0;
                end
            end else if (push) begin
                r_cnt[r_mat] <= r_cnt[r_mat] + VTX_PER_FACE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_code <= i_block_code;
        end
        if (push) begin
            r_face.x    <= r_x;
            r_face.y    <= r_y;
            r_face.z    <= r_z;
            r_face.dir  <= r_pend_dir;
            r_face.mat  <= 3'(r_mat);
            r_face.base <= r_cnt[r_mat];
            r_face.last <= push_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_face  = r_face;

endmodule

>>> rtl/voxel_face_culling_mesher.sv
// voxel face culling mesher: a write request, a clear request, a mesh request outside the chunk and
// an unused function code end with the dispatch step, a mesh request on an air voxel with the center
// read, and a mesh request on a solid voxel runs accept, dispatch, center read, six neighbor tests
// and the last-face flush. the single read port of the voxel ram allows one neighbor test per cycle,
// unless the face output stalls, which holds the request. faces of one voxel come out in the order
// +x +y -x -y +z -z, each with the vertex count of its material before the face; o_stall is low
// only between requests. the voxel ram is not cleared: mesh only voxels whose neighbors were written.
// depends on vfcm_pkg, vfcm_cfg, vfcm_ram, vfcm_ctrl
module voxel_face_culling_mesher
    import vfcm_pkg::*;
#(
    parameter int SIZE_X        = DEF_SIZE_X,
    parameter int SIZE_Y        = DEF_SIZE_Y,
    parameter int SIZE_Z        = DEF_SIZE_Z,
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [COORD_W-1:0] i_pos_z,
    input  logic [CODE_W-1:0]  i_block_code,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_face_x,
    output logic [COORD_W-1:0] o_face_y,
    output logic [COORD_W-1:0] o_face_z,
    output logic [2:0]         o_face_direction,
    output logic [2:0]         o_face_material,
    output logic [CNT_W-1:0]   o_face_vertex_base,
    output logic               o_last_face
);

    localparam int AW    = $clog2(SIZE_X) + $clog2(SIZE_Y) + $clog2(SIZE_Z);
    localparam int DEPTH = 2 ** AW;

    t_cfg              cfg;
    t_face             face;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CODE_W-1:0] ram_wdata, ram_rdata;

    vfcm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vfcm_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    vfcm_ctrl #(
        .SIZE_X        (SIZE_X),
        .SIZE_Y        (SIZE_Y),
        .SIZE_Z        (SIZE_Z),
        .MAX_MATERIALS (MAX_MATERIALS),
        .AW            (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_block_code (i_block_code),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_face       (face)
    );

    assign o_face_x           = face.x;
    assign o_face_y           = face.y;
    assign o_face_z           = face.z;
    assign o_face_direction   = face.dir;
    assign o_face_material    = face.mat;
    assign o_face_vertex_base = face.base;
    assign o_last_face        = face.last;

endmodule

>>> rtl/vfcm_chk.sv
// port-level checker for the voxel face culling mesher, bound to the top level
// depends on vfcm_pkg and voxel_face_culling_mesher_macros.svh
`include "voxel_face_culling_mesher_macros.svh"

module vfcm_chk
    import vfcm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [COORD_W-1:0] o_face_x,
    input logic [COORD_W-1:0] o_face_y,
    input logic [COORD_W-1:0] o_face_z,
    input logic [2:0]         o_face_direction,
    input logic [2:0]         o_face_material,
    input logic [CNT_W-1:0]   o_face_vertex_base,
    input logic               o_last_face
);

    logic [3*COORD_W+CNT_W+6:0] face_bits;

    assign face_bits = {o_face_x, o_face_y, o_face_z, o_face_direction, o_face_material,
                        o_face_vertex_base, o_last_face};

    // a stalled face holds
    `VFCM_ASSERT(a_face_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(face_bits))

    // the sequencer is busy right after taking a request
    `VFCM_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)

    // counters only move in steps of four vertices
    `VFCM_ASSERT(a_base_aligned, i_clk, i_rst_n, o_valid |-> o_face_vertex_base[1:0] == 2'b00)

    `VFCM_ASSERT(a_dir_range, i_clk, i_rst_n, o_valid |-> o_face_direction <= DIR_NZ)

    // reset leaves no face pending and the input open
    `VFCM_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind voxel_face_culling_mesher vfcm_chk u_vfcm_chk (.*);

>>> verif/tb_voxel_face_culling_mesher.sv
// testbench for voxel_face_culling_mesher: directed corner, register and clear cases, output
// hold-off and random traffic, each face checked against a local model
// depends on vfcm_pkg and the mesher rtl
module tb_voxel_face_culling_mesher;
    timeunit 1ns;
    timeprecision 1ps;
    import vfcm_pkg::*;

    localparam int SIZE_X = DEF_SIZE_X;
    localparam int SIZE_Y = DEF_SIZE_Y;
    localparam int SIZE_Z = DEF_SIZE_Z;
    localparam int CELLS  = SIZE_X * SIZE_Y * SIZE_Z;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS  = 175;
    localparam int SEGMENT_REQUESTS = 40;
    localparam int MAX_WAIT         = 11;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_func = FUNC_WRITE;
    logic [COORD_W-1:0] i_pos_x = '0;
    logic [COORD_W-1:0] i_pos_y = '0;
    logic [COORD_W-1:0] i_pos_z = '0;
    logic [CODE_W-1:0]  i_block_code = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [COORD_W-1:0] o_face_x;
    logic [COORD_W-1:0] o_face_y;
    logic [COORD_W-1:0] o_face_z;
    logic [2:0]         o_face_direction;
    logic [2:0]         o_face_material;
    logic [CNT_W-1:0]   o_face_vertex_base;
    logic               o_last_face;

    // local copy of the block state
    logic [CODE_W-1:0] voxel_mem [CELLS];
    bit                written [CELLS];
    logic [CNT_W-1:0]  vtx_count [DEF_MAX_MATERIALS];
    logic [CODE_W-1:0] cfg_air;
    logic [CODE_W-1:0] cfg_water;
    logic [CODE_W-1:0] cfg_trunk;
    logic [CODE_W-1:0] cfg_matcnt;

    t_face faces_due [$];

    int  errors = 0;
    int  faces_checked = 0;
    int  requests_sent = 0;
    int  settings_used = 0;
    bit  sender_pace = 1'b1;
    bit  sink_pace = 1'b1;
    int  stall_left = 0;
    int  hold_left = 0;

    voxel_face_culling_mesher dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int cell_of(input int x, input int y, input int z);
        return (z * SIZE_Y + y) * SIZE_X + x;
    endfunction

    function automatic bit neighbor_at(input logic [2:0] dir, input int x, input int y,
                                       input int z, output int nx, output int ny,
                                       output int nz);
        nx = x;
        ny = y;
        nz = z;
        case (dir)
            DIR_PX:  nx = x + 1;
            DIR_PY:  ny = y + 1;
            DIR_NX:  nx = x - 1;
            DIR_NY:  ny = y - 1;
            DIR_PZ:  nz = z + 1;
            default: nz = z - 1;
        endcase
        return nx >= 0 && nx < SIZE_X && ny >= 0 && ny < SIZE_Y && nz >= 0 && nz < SIZE_Z;
    endfunction

    function automatic void compute_faces(input int x, input int y, input int z);
        t_face             faces [6];
        logic [CODE_W-1:0] center;
        logic [CODE_W-1:0] nbr;
        int                eff;
        int                mat;
        int                n;
        int                nx;
        int                ny;
        int                nz;
        bit                force_all;
        bit                open_side;
        center = voxel_mem[cell_of(x, y, z)];
        if (center == cfg_air)
            return;
        eff = (cfg_matcnt == 0) ? 1 : int'(cfg_matcnt);
        if (eff > DEF_MAX_MATERIALS)
            eff = DEF_MAX_MATERIALS;
        mat = int'(center) - int'(MAT_BIAS);
        if (mat < 0)
            mat = 0;
        if (mat > eff - 1)
            mat = eff - 1;
        // a trunk code below the bias matches no material
        force_all = (mat == int'(cfg_trunk) - int'(MAT_BIAS));
        n = 0;
        for (int d = 0; d < 6; d++) begin
            open_side = 1'b1;
            if (neighbor_at(3'(d), x, y, z, nx, ny, nz)) begin
                nbr = voxel_mem[cell_of(nx, ny, nz)];
                open_side = (nbr == cfg_air) || (nbr == cfg_water);
            end
            if (force_all || open_side) begin
                faces[n].x    = COORD_W'(x);
                faces[n].y    = COORD_W'(y);
                faces[n].z    = COORD_W'(z);
                faces[n].dir  = 3'(d);
                faces[n].mat  = 3'(mat);
                faces[n].base = vtx_count[mat];
                faces[n].last = 1'b0;
                vtx_count[mat] = vtx_count[mat] + VTX_PER_FACE;
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            faces[i].last = (i == n - 1);
            faces_due.push_back(faces[i]);
        end
    endfunction

    function automatic void apply_request(input logic [1:0] func, input int x, input int y,
                                          input int z, input logic [CODE_W-1:0] code);
        if (x >= SIZE_X || y >= SIZE_Y || z >= SIZE_Z)
            return;
        case (func)
            FUNC_WRITE: begin
                voxel_mem[cell_of(x, y, z)] = code;
                written[cell_of(x, y, z)] = 1'b1;
            end
            FUNC_MESH: compute_faces(x, y, z);
            FUNC_CLEAR: begin
                foreach (vtx_count[i])
                    vtx_count[i] = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 9))
            0, 1:    return cfg_air;
            2:       return cfg_water;
            3:       return cfg_trunk;
            default: return CODE_W'($urandom_range(0, 15));
        endcase
    endfunction

    // mostly near the faces and the middle so that writes end up next to each other
    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 2);
            4, 5, 6:    return $urandom_range(13, 15);
            7, 8:       return $urandom_range(7, 8);
            default:    return $urandom_range(0, 15);
        endcase
    endfunction

    // receiver side: random stall per face, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin : face_check
        t_face want;
        if (i_rst_n && o_valid && !i_stall) begin
            faces_checked++;
            if (faces_due.size() == 0) begin
                $error("face with nothing pending: x %0d y %0d z %0d dir %0d",
                       o_face_x, o_face_y, o_face_z, o_face_direction);
                errors++;
            end else begin
                want = faces_due.pop_front();
                compare_field("face_x", want.x, o_face_x);
                compare_field("face_y", want.y, o_face_y);
                compare_field("face_z", want.z, o_face_z);
                compare_field("face_direction", want.dir, o_face_direction);
                compare_field("face_material", want.mat, o_face_material);
                compare_field("face_vertex_base", want.base, o_face_vertex_base);
                compare_field("last_face", want.last, o_last_face);
            end
            stall_left = sink_pace ? $urandom_range(0, MAX_WAIT) : 0;
        end
    end

    // valid stays high after acceptance; the next request or wait_idle takes it over
    task automatic send_request(input logic [1:0] func, input int x, input int y, input int z,
                                input logic [CODE_W-1:0] code);
        int gap;
        gap = sender_pace ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func       = func;
        i_pos_x      = COORD_W'(x);
        i_pos_y      = COORD_W'(y);
        i_pos_z      = COORD_W'(z);
        i_block_code = code;
        i_valid      = 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_request(func, x, y, z, code);
        if (func != FUNC_UNUSED)
            requests_sent++;
    endtask

    task automatic wait_idle();
        int waited;
        @(negedge i_clk);
        i_valid = 1'b0;
        waited = 0;
        while (faces_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (faces_due.size() != 0) begin
            $error("%0d expected faces never arrived", faces_due.size());
            errors++;
            faces_due.delete();
        end
        // writes and clears give no face but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // a mesh request only after its voxel, and for solid voxels its neighbors, hold codes
    task automatic mesh_voxel(input int x, input int y, input int z);
        int nx;
        int ny;
        int nz;
        if (!written[cell_of(x, y, z)])
            send_request(FUNC_WRITE, x, y, z, random_code());
        if (voxel_mem[cell_of(x, y, z)] != cfg_air) begin
            for (int d = 0; d < 6; d++) begin
                if (neighbor_at(3'(d), x, y, z, nx, ny, nz) && !written[cell_of(nx, ny, nz)])
                    send_request(FUNC_WRITE, nx, ny, nz, random_code());
            end
        end
        send_request(FUNC_MESH, x, y, z, CODE_W'($urandom_range(0, 15)));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CODE_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        string              name;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = ($urandom() & ~32'hF) | PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_AIR: begin
                name = "air_code";
                cfg_air = value;
            end
            REG_WATER: begin
                name = "water_code";
                cfg_water = value;
            end
            REG_TRUNK: begin
                name = "trunk_code";
                cfg_trunk = value;
            end
            default: begin
                name = "material_count";
                cfg_matcnt = value;
            end
        endcase
        compare_field(name, PDATA_W'(value), readback);
    endtask

    task automatic apply_config(input logic [CODE_W-1:0] air, input logic [CODE_W-1:0] water,
                                input logic [CODE_W-1:0] trunk,
                                input logic [CODE_W-1:0] matcnt);
        wait_idle();
        write_register(REG_AIR, air);
        write_register(REG_WATER, water);
        write_register(REG_TRUNK, trunk);
        write_register(REG_MATCNT, matcnt);
        settings_used++;
    endtask

    task automatic random_config();
        logic [CODE_W-1:0] air;
        logic [CODE_W-1:0] water;
        logic [CODE_W-1:0] trunk;
        logic [CODE_W-1:0] matcnt;
        case ($urandom_range(0, 3))
            0:       air = 4'd15;
            1:       air = CODE_W'($urandom_range(0, 15));
            default: air = AIR_RST;
        endcase
        case ($urandom_range(0, 3))
            0:       water = 4'd0;
            1:       water = 4'd15;
            2:       water = CODE_W'($urandom_range(0, 15));
            default: water = WATER_RST;
        endcase
        case ($urandom_range(0, 4))
            0:       trunk = CODE_W'($urandom_range(0, 1));
            1:       trunk = 4'd15;
            default: trunk = CODE_W'($urandom_range(2, 9));
        endcase
        case ($urandom_range(0, 5))
            0:       matcnt = 4'd0;
            1:       matcnt = 4'd1;
            2:       matcnt = CODE_W'($urandom_range(9, 15));
            3:       matcnt = CODE_W'($urandom_range(2, 7));
            default: matcnt = MATCNT_RST;
        endcase
        apply_config(air, water, trunk, matcnt);
    endtask

    task automatic test_corner_faces();
        // low corner: air, water, outside and one solid neighbor
        send_request(FUNC_WRITE, 0, 0, 0, 4'd2);
        send_request(FUNC_WRITE, 1, 0, 0, cfg_air);
        send_request(FUNC_WRITE, 0, 1, 0, cfg_water);
        send_request(FUNC_WRITE, 0, 0, 1, 4'd5);
        mesh_voxel(0, 0, 0);
        // high corner, code above the material range
        send_request(FUNC_WRITE, 15, 15, 15, 4'd15);
        send_request(FUNC_WRITE, 14, 15, 15, 4'd15);
        send_request(FUNC_WRITE, 15, 14, 15, cfg_air);
        send_request(FUNC_WRITE, 15, 15, 14, 4'd9);
        mesh_voxel(15, 15, 15);
        mesh_voxel(1, 0, 0);
        send_request(FUNC_UNUSED, 15, 0, 15, 4'd15);
        send_request(FUNC_UNUSED, 0, 15, 0, 4'd0);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        apply_config(AIR_RST, WATER_RST, 4'd2, MATCNT_RST);
        mesh_voxel(0, 0, 0);
        // trunk codes below the bias must not force faces on materials 7 and 6
        apply_config(AIR_RST, WATER_RST, 4'd1, MATCNT_RST);
        mesh_voxel(15, 15, 15);
        apply_config(AIR_RST, WATER_RST, 4'd0, MATCNT_RST);
        send_request(FUNC_WRITE, 15, 15, 15, 4'd8);
        mesh_voxel(15, 15, 15);
        apply_config(AIR_RST, WATER_RST, 4'd15, 4'd0);
        mesh_voxel(15, 15, 15);
        apply_config(AIR_RST, WATER_RST, TRUNK_RST, 4'd15);
        mesh_voxel(15, 15, 15);
        mesh_voxel(14, 15, 15);
        apply_config(AIR_RST, WATER_RST, TRUNK_RST, 4'd1);
        mesh_voxel(0, 0, 0);
        apply_config(AIR_RST, WATER_RST, TRUNK_RST, 4'd9);
        mesh_voxel(15, 15, 15);
        apply_config(4'd15, 4'd0, TRUNK_RST, MATCNT_RST);
        mesh_voxel(0, 0, 0);
        mesh_voxel(14, 15, 15);
        apply_config(AIR_RST, WATER_RST, TRUNK_RST, MATCNT_RST);
    endtask

    task automatic test_counter_clear();
        send_request(FUNC_CLEAR, 0, 0, 0, 4'd0);
        mesh_voxel(0, 0, 0);
        send_request(FUNC_CLEAR, 15, 15, 15, 4'd15);
        send_request(FUNC_CLEAR, 15, 15, 15, 4'd15);
        mesh_voxel(15, 15, 15);
        wait_idle();
    endtask

    task automatic test_output_hold_off();
        send_request(FUNC_WRITE, 8, 8, 8, TRUNK_RST);
        mesh_voxel(8, 8, 8);
        wait_idle();
        sender_pace = 1'b0;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        repeat (10) send_request(FUNC_MESH, 8, 8, 8, CODE_W'($urandom_range(0, 15)));
        wait_idle();
        sender_pace = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start;
        int next_segment;
        start = requests_sent;
        next_segment = 0;
        while (requests_sent - start < RANDOM_REQUESTS) begin
            if (requests_sent - start >= next_segment) begin
                random_config();
                sender_pace = ($urandom_range(0, 3) != 0);
                sink_pace = ($urandom_range(0, 3) != 0);
                next_segment += SEGMENT_REQUESTS;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    mesh_voxel(pick_coord(), pick_coord(), pick_coord());
                8, 9, 10, 11, 12, 13, 14, 15:
                    send_request(FUNC_WRITE, pick_coord(), pick_coord(), pick_coord(),
                                 random_code());
                16:
                    send_request(FUNC_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 15), CODE_W'($urandom_range(0, 15)));
                17:
                    send_request(FUNC_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 15), CODE_W'($urandom_range(0, 15)));
                18:
                    send_request(FUNC_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 15), CODE_W'($urandom_range(0, 15)));
                default:
                    mesh_voxel($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15));
            endcase
        end
        wait_idle();
        sender_pace = 1'b1;
        sink_pace = 1'b1;
    endtask

    initial begin
        cfg_air    = AIR_RST;
        cfg_water  = WATER_RST;
        cfg_trunk  = TRUNK_RST;
        cfg_matcnt = MATCNT_RST;
        foreach (vtx_count[i])
            vtx_count[i] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_faces();
        test_register_extremes();
        test_counter_clear();
        test_output_hold_off();
        test_random_traffic();

        wait_idle();
        $display("run: %0d requests over %0d register settings, %0d faces compared",
                 requests_sent, settings_used, faces_checked);
        $display("run: corners, register extremes, clears, long output hold-off and random"
                 , " traffic");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> voxel_face_culling_mesher.f
+incdir+rtl
rtl/vfcm_pkg.sv
rtl/vfcm_ram.sv
rtl/vfcm_cfg.sv
rtl/vfcm_ctrl.sv
rtl/voxel_face_culling_mesher.sv
rtl/vfcm_chk.sv
verif/tb_voxel_face_culling_mesher.sv
